FILE: design/sfr_pkg.sv
// Shared constants, types and helper functions for the supervisory frame receiver.
// Used by sfr_parser and supervisory_frame_receiver; depends on nothing.
`timescale 1ns / 1ps

package sfr_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ADDR_MAIN = 8'h03;
    localparam logic [7:0] ADDR_ALT  = 8'h01;

    localparam logic [7:0] CTRL_SET  = 8'h03;
    localparam logic [7:0] CTRL_UA   = 8'h07;
    localparam logic [7:0] CTRL_DISC = 8'h0B;
    localparam logic [7:0] CTRL_RR0  = 8'h05;
    localparam logic [7:0] CTRL_RR1  = 8'h85;
    localparam logic [7:0] CTRL_REJ0 = 8'h01;
    localparam logic [7:0] CTRL_REJ1 = 8'h81;
    localparam logic [7:0] CTRL_NONE = 8'hFF;
    localparam logic [7:0] SEQ_MASK  = 8'h80;

    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_SET  = 3'd1,
        KIND_UA   = 3'd2,
        KIND_DISC = 3'd3,
        KIND_RR   = 3'd4,
        KIND_REJ  = 3'd5
    } kind_t;

    typedef enum logic [4:0] {
        ST_HUNT  = 5'b00001,
        ST_FLAG  = 5'b00010,
        ST_ADDR  = 5'b00100,
        ST_CTRL  = 5'b01000,
        ST_CHECK = 5'b10000
    } parse_state_t;

    typedef struct packed {
        logic  done;
        kind_t kind;
        logic  seq;
    } result_t;

    function automatic kind_t classify(input logic [7:0] c);
        kind_t k;
        unique case (c)
            CTRL_SET:            k = KIND_SET;
            CTRL_UA:             k = KIND_UA;
            CTRL_DISC:           k = KIND_DISC;
            CTRL_RR0, CTRL_RR1:  k = KIND_RR;
            CTRL_REJ0, CTRL_REJ1: k = KIND_REJ;
            default:             k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] held_control(input kind_t k, input logic s);
        logic [7:0] hi;
        logic [7:0] c;
        hi = s ? SEQ_MASK : 8'h00;
        unique case (k)
            KIND_SET:  c = CTRL_SET;
            KIND_UA:   c = CTRL_UA;
            KIND_DISC: c = CTRL_DISC;
            KIND_RR:   c = CTRL_RR0 | hi;
            KIND_REJ:  c = CTRL_REJ0 | hi;
            default:   c = CTRL_NONE;
        endcase
        return c;
    endfunction

    function automatic logic check_ok(input kind_t k, input logic s, input logic [7:0] b);
        logic [7:0] c;
        c = held_control(k, s);
        return (k != KIND_NONE) &&
               ((b == (ADDR_MAIN ^ c)) || ((k == KIND_DISC) && (b == (ADDR_ALT ^ c))));
    endfunction

endpackage

FILE: design/sfr_parser.sv
// Frame parser: the parse state, the held control kind and the per-byte result logic.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  logic [7:0]       rx_byte,
    output sfr_pkg::result_t result
);

    sfr_pkg::parse_state_t state_reg, state_next;
    sfr_pkg::kind_t        kind_reg, kind_next;
    logic                  seq_reg, seq_next;
    sfr_pkg::kind_t        ctrl_kind;

    assign ctrl_kind = sfr_pkg::classify(rx_byte);

    always_comb begin
        state_next  = sfr_pkg::ST_HUNT;
        kind_next   = kind_reg;
        seq_next    = seq_reg;
        result.done = 1'b0;
        result.kind = sfr_pkg::KIND_NONE;
        result.seq  = 1'b0;
        unique case (state_reg)
            sfr_pkg::ST_FLAG: begin
                if (rx_byte == sfr_pkg::FLAG_BYTE) begin
                    state_next = sfr_pkg::ST_FLAG;
                end else if (rx_byte == sfr_pkg::ADDR_MAIN || rx_byte == sfr_pkg::ADDR_ALT) begin
                    state_next = sfr_pkg::ST_ADDR;
                end
            end
            sfr_pkg::ST_ADDR: begin
                if (rx_byte == sfr_pkg::FLAG_BYTE) begin
                    state_next = sfr_pkg::ST_FLAG;
                end else if (ctrl_kind != sfr_pkg::KIND_NONE) begin
                    state_next = sfr_pkg::ST_CTRL;
                    kind_next  = ctrl_kind;
                    seq_next   = rx_byte[7];
                end
            end
            sfr_pkg::ST_CTRL: begin
                if (rx_byte == sfr_pkg::FLAG_BYTE) begin
                    state_next = sfr_pkg::ST_FLAG;
                end else if (sfr_pkg::check_ok(kind_reg, seq_reg, rx_byte)) begin
                    state_next = sfr_pkg::ST_CHECK;
                end
            end
            sfr_pkg::ST_CHECK: begin
                if (rx_byte == sfr_pkg::FLAG_BYTE) begin
                    result.done = 1'b1;
                    result.kind = kind_reg;
                    result.seq  = (kind_reg == sfr_pkg::KIND_RR || kind_reg == sfr_pkg::KIND_REJ)
                                  ? seq_reg : 1'b0;
                end
            end
            default: begin
                if (rx_byte == sfr_pkg::FLAG_BYTE) begin
                    state_next = sfr_pkg::ST_FLAG;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sfr_pkg::ST_HUNT;
            kind_reg  <= sfr_pkg::KIND_NONE;
            seq_reg   <= 1'b0;
        end else if (step_en) begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            seq_reg   <= seq_next;
        end
    end

endmodule

FILE: design/supervisory_frame_receiver.sv
// Top level of the supervisory frame receiver: input register, parser and result register.
// Depends on sfr_pkg and sfr_parser.
`timescale 1ns / 1ps

//  Channel   Direction  Ports                                   Request
//  input     in         s_valid s_ready s_rx_byte               one received byte
//  result    out        m_valid m_ready m_frame_done
//                       m_frame_kind m_seq_bit                  one result per byte
//
// An accepted byte sits in the input register; the parser's result for it is loaded into the
// result register, and m_valid set, once the result register is free (empty or being taken).
// A new byte is taken every cycle while results are drained. Reset clears the parse state
// and both valid flags. A stalled result holds the result register and then the input
// register; both stay full until the result is taken.

module supervisory_frame_receiver (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_frame_done,
    output logic [2:0] m_frame_kind,
    output logic       m_seq_bit
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg;
    sfr_pkg::result_t  out_result_reg;
    sfr_pkg::result_t  step_result;
    logic              out_free;
    logic              step_en;

    assign out_free = !out_valid_reg || m_ready;
    assign step_en  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    sfr_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .rx_byte (in_byte_reg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (step_en) begin
            out_result_reg <= step_result;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_frame_done = out_result_reg.done;
    assign m_frame_kind = out_result_reg.kind;
    assign m_seq_bit    = out_result_reg.seq;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for supervisory_frame_receiver: directed frames, then randomized
// noisy frame traffic; each result is checked against the table or a behavioral parser.
// Depends on sfr_pkg and the supervisory_frame_receiver RTL.

module tb_top;

    typedef struct packed {
        logic [7:0]       rx;
        logic             typed;
        sfr_pkg::result_t want;
    } stim_row_t;

    localparam int      TOTAL_BYTES  = 1782;
    localparam int      CALM_AFTER   = 1500;
    localparam int      HOLD_AFTER   = 600;
    localparam int      HOLD_CYCLES  = 300;
    localparam int      DRAIN_CYCLES = 16;
    localparam int      CYCLE_LIMIT  = 400000;
    localparam int      MAX_REPORTS  = 10;
    localparam int      TABLE_ROWS   = 32;
    localparam sfr_pkg::result_t NO_FRAME = '{1'b0, sfr_pkg::KIND_NONE, 1'b0};

    localparam logic [7:0] CONTROLS [7] = '{
        sfr_pkg::CTRL_SET, sfr_pkg::CTRL_UA, sfr_pkg::CTRL_DISC, sfr_pkg::CTRL_RR0,
        sfr_pkg::CTRL_RR1, sfr_pkg::CTRL_REJ0, sfr_pkg::CTRL_REJ1
    };

    localparam stim_row_t DIRECTED [TABLE_ROWS] = '{
        '{8'hFF,              1'b1, NO_FRAME},
        '{sfr_pkg::FLAG_BYTE, 1'b0, NO_FRAME},
        '{sfr_pkg::FLAG_BYTE, 1'b0, NO_FRAME},
        '{sfr_pkg::ADDR_MAIN, 1'b0, NO_FRAME},
        '{sfr_pkg::CTRL_SET,  1'b0, NO_FRAME},
        '{8'h00,              1'b0, NO_FRAME},
        '{sfr_pkg::FLAG_BYTE, 1'b1, '{1'b1, sfr_pkg::KIND_SET, 1'b0}},
        '{sfr_pkg::FLAG_BYTE, 1'b0, NO_FRAME},
        '{sfr_pkg::ADDR_ALT,  1'b0, NO_FRAME},
        '{sfr_pkg::CTRL_UA,   1'b0, NO_FRAME},
        '{8'h04,              1'b0, NO_FRAME},
        '{sfr_pkg::FLAG_BYTE, 1'b1, '{1'b1, sfr_pkg::KIND_UA, 1'b0}},
        '{sfr_pkg::FLAG_BYTE, 1'b0, NO_FRAME},
        '{sfr_pkg::ADDR_MAIN, 1'b0, NO_FRAME},
        '{sfr_pkg::CTRL_DISC, 1'b0, NO_FRAME},
        '{8'h0A,              1'b0, NO_FRAME},
        '{sfr_pkg::FLAG_BYTE, 1'b1, '{1'b1, sfr_pkg::KIND_DISC, 1'b0}},
        '{sfr_pkg::FLAG_BYTE, 1'b0, NO_FRAME},
        '{sfr_pkg::ADDR_ALT,  1'b0, NO_FRAME},
        '{sfr_pkg::FLAG_BYTE, 1'b0, NO_FRAME},
        '{sfr_pkg::ADDR_MAIN, 1'b0, NO_FRAME},
        '{sfr_pkg::CTRL_RR0,  1'b0, NO_FRAME},
        '{sfr_pkg::FLAG_BYTE, 1'b0, NO_FRAME},
        '{sfr_pkg::ADDR_ALT,  1'b0, NO_FRAME},
        '{sfr_pkg::CTRL_RR1,  1'b0, NO_FRAME},
        '{8'h86,              1'b0, NO_FRAME},
        '{sfr_pkg::FLAG_BYTE, 1'b1, '{1'b1, sfr_pkg::KIND_RR, 1'b1}},
        '{sfr_pkg::FLAG_BYTE, 1'b0, NO_FRAME},
        '{sfr_pkg::ADDR_MAIN, 1'b0, NO_FRAME},
        '{sfr_pkg::CTRL_REJ1, 1'b0, NO_FRAME},
        '{8'h82,              1'b0, NO_FRAME},
        '{sfr_pkg::FLAG_BYTE, 1'b1, '{1'b1, sfr_pkg::KIND_REJ, 1'b1}}
    };

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic       m_frame_done;
    logic [2:0] m_frame_kind;
    logic       m_seq_bit;

    sfr_pkg::parse_state_t rx_state = sfr_pkg::ST_HUNT;
    sfr_pkg::kind_t        rx_kind  = sfr_pkg::KIND_NONE;
    logic [7:0]            rx_ctrl  = 8'h00;

    sfr_pkg::result_t frame_reports [$];
    logic [7:0] line_bytes [$];
    int         bytes_taken = 0;
    int         mismatches  = 0;
    int         cycles_run  = 0;
    int         send_run    = 0;
    int         ready_run   = 0;
    bit         calm        = 1'b0;
    bit         held_off    = 1'b0;

    supervisory_frame_receiver i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_done (m_frame_done),
        .m_frame_kind (m_frame_kind),
        .m_seq_bit    (m_seq_bit)
    );

    always #5 aclk = ~aclk;

    function automatic sfr_pkg::result_t parse_byte(input logic [7:0] rx);
        sfr_pkg::result_t found;
        sfr_pkg::kind_t   k;
        found = NO_FRAME;
        case (rx)
            sfr_pkg::CTRL_SET:                     k = sfr_pkg::KIND_SET;
            sfr_pkg::CTRL_UA:                      k = sfr_pkg::KIND_UA;
            sfr_pkg::CTRL_DISC:                    k = sfr_pkg::KIND_DISC;
            sfr_pkg::CTRL_RR0, sfr_pkg::CTRL_RR1:   k = sfr_pkg::KIND_RR;
            sfr_pkg::CTRL_REJ0, sfr_pkg::CTRL_REJ1: k = sfr_pkg::KIND_REJ;
            default:                               k = sfr_pkg::KIND_NONE;
        endcase
        case (rx_state)
            sfr_pkg::ST_FLAG: begin
                if (rx == sfr_pkg::FLAG_BYTE) begin
                    rx_state = sfr_pkg::ST_FLAG;
                end else if (rx == sfr_pkg::ADDR_MAIN || rx == sfr_pkg::ADDR_ALT) begin
                    rx_state = sfr_pkg::ST_ADDR;
                end else begin
                    rx_state = sfr_pkg::ST_HUNT;
                end
            end
            sfr_pkg::ST_ADDR: begin
                if (rx == sfr_pkg::FLAG_BYTE) begin
                    rx_state = sfr_pkg::ST_FLAG;
                end else if (k == sfr_pkg::KIND_NONE) begin
                    rx_state = sfr_pkg::ST_HUNT;
                end else begin
                    rx_kind  = k;
                    rx_ctrl  = rx;
                    rx_state = sfr_pkg::ST_CTRL;
                end
            end
            sfr_pkg::ST_CTRL: begin
                if (rx == sfr_pkg::FLAG_BYTE) begin
                    rx_state = sfr_pkg::ST_FLAG;
                end else if (rx == (sfr_pkg::ADDR_MAIN ^ rx_ctrl) ||
                             (rx_kind == sfr_pkg::KIND_DISC &&
                              rx == (sfr_pkg::ADDR_ALT ^ rx_ctrl))) begin
                    rx_state = sfr_pkg::ST_CHECK;
                end else begin
                    rx_state = sfr_pkg::ST_HUNT;
                end
            end
            sfr_pkg::ST_CHECK: begin
                if (rx == sfr_pkg::FLAG_BYTE) begin
                    found.done = 1'b1;
                    found.kind = rx_kind;
                    found.seq  = rx_ctrl[7];
                end
                rx_state = sfr_pkg::ST_HUNT;
            end
            default: begin
                rx_state = (rx == sfr_pkg::FLAG_BYTE) ? sfr_pkg::ST_FLAG : sfr_pkg::ST_HUNT;
            end
        endcase
        return found;
    endfunction

    function automatic logic [7:0] pick_address();
        if ($urandom_range(0, 9) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        return $urandom_range(0, 1) ? sfr_pkg::ADDR_MAIN : sfr_pkg::ADDR_ALT;
    endfunction

    function automatic logic [7:0] pick_control();
        if ($urandom_range(0, 9) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        return CONTROLS[$urandom_range(0, 6)];
    endfunction

    // Mostly well-formed frames with random content; the rest carry noise,
    // restarts, bad check bytes or a missing closing flag.
    task automatic queue_random_frame();
        logic [7:0] ctrl;
        logic [7:0] chk;
        int         roll;
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 4)) line_bytes.push_back(8'($urandom_range(0, 255)));
        end
        line_bytes.push_back(sfr_pkg::FLAG_BYTE);
        if ($urandom_range(0, 7) == 0) begin
            line_bytes.push_back(sfr_pkg::FLAG_BYTE);
        end
        line_bytes.push_back(pick_address());
        if ($urandom_range(0, 11) == 0) begin
            line_bytes.push_back(sfr_pkg::FLAG_BYTE);
            line_bytes.push_back(pick_address());
        end
        ctrl = pick_control();
        line_bytes.push_back(ctrl);
        if ($urandom_range(0, 11) == 0) begin
            line_bytes.push_back(sfr_pkg::FLAG_BYTE);
            line_bytes.push_back(pick_address());
            ctrl = pick_control();
            line_bytes.push_back(ctrl);
        end
        chk  = sfr_pkg::ADDR_MAIN ^ ctrl;
        roll = $urandom_range(0, 19);
        if (ctrl == sfr_pkg::CTRL_DISC && roll < 10) begin
            chk = sfr_pkg::ADDR_ALT ^ ctrl;
        end else if (roll == 0) begin
            chk = sfr_pkg::ADDR_ALT ^ ctrl;
        end else if (roll < 3) begin
            chk = 8'($urandom_range(0, 255));
        end
        line_bytes.push_back(chk);
        line_bytes.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                         : sfr_pkg::FLAG_BYTE);
    endtask

    task automatic send_byte(input logic [7:0] rx, input logic typed,
                             input sfr_pkg::result_t want);
        sfr_pkg::result_t predicted;
        s_valid   <= 1'b1;
        s_rx_byte <= rx;
        do @(posedge aclk); while (!s_ready);
        predicted = parse_byte(rx);
        frame_reports.push_back(typed ? want : predicted);
        bytes_taken++;
        if (bytes_taken >= CALM_AFTER) begin
            calm = 1'b1;
        end
        if (!calm) begin
            if (send_run > 0) begin
                send_run--;
            end else begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
                send_run = $urandom_range(1, 30);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_run = $urandom_range(1, 30);
        foreach (DIRECTED[i]) begin
            send_byte(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].want);
        end
        while (bytes_taken < TOTAL_BYTES) begin
            if (line_bytes.size() == 0) begin
                queue_random_frame();
            end
            send_byte(line_bytes.pop_front(), 1'b0, NO_FRAME);
        end
        s_valid <= 1'b0;
        while (frame_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && frame_reports.size() == 0) begin
            $display("supervisory_frame_receiver verification clean");
        end else begin
            $display("supervisory_frame_receiver verification failed");
        end
        $finish;
    end

    // The long hold-off lets the sender keep offering until the block backs up.
    initial begin
        do @(posedge aclk); while (!aresetn);
        ready_run = $urandom_range(1, 40);
        forever begin
            if (!held_off && bytes_taken >= HOLD_AFTER) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (calm || ready_run > 0) begin
                m_ready <= 1'b1;
                if (ready_run > 0) begin
                    ready_run--;
                end
                @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
                ready_run = $urandom_range(1, 40);
            end
        end
    end

    always @(posedge aclk) begin
        sfr_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (frame_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected result: done=%0b kind=%0d seq=%0b",
                             m_frame_done, m_frame_kind, m_seq_bit);
                end
            end else begin
                want = frame_reports.pop_front();
                if (m_frame_done !== want.done || m_frame_kind !== want.kind ||
                    m_seq_bit !== want.seq) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display({"mismatch: expected done=%0b kind=%0d seq=%0b, ",
                                  "got done=%0b kind=%0d seq=%0b"},
                                 want.done, want.kind, want.seq,
                                 m_frame_done, m_frame_kind, m_seq_bit);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles_run++;
        if (cycles_run >= CYCLE_LIMIT) begin
            $display("supervisory_frame_receiver verification failed");
            $finish;
        end
    end

endmodule

FILE: files.f
design/sfr_pkg.sv
design/sfr_parser.sv
design/supervisory_frame_receiver.sv
bench/tb_top.sv
